// File: design/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared word types, CORDIC constants and helper functions for the
// differential-drive motion model pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddm_pkg;

	localparam int CORDIC_ITERS = 24;
	localparam int ANG_W = 34;

	localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
	localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q30 = ANG_W'(32'h26DD_3B6A);
	localparam logic signed [ANG_W-1:0] PI_Q30 = ANG_W'(TWO_PI_Q60 >> 31);
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = ANG_W'(TWO_PI_Q60 >> 32);
	localparam logic [63:0] REDUCE_FLOOR = 64'h0800_0000_0000_0000;

	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [31:0] heading;
		logic signed [31:0] lin_speed;
		logic signed [31:0] turn_rate;
		logic [19:0]        step_time;
	} pose_t;

	typedef struct packed {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [31:0] new_heading;
		logic signed [31:0] jac_x_theta;
		logic signed [31:0] jac_y_theta;
		logic signed [31:0] noise_x_v;
		logic signed [31:0] noise_y_v;
		logic [19:0]        noise_theta_w;
	} pred_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] z;
		logic                    flip;
		pose_t                   pose;
	} angle_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] x;
		logic signed [ANG_W-1:0] y;
		logic                    flip;
		pose_t                   pose;
	} trig_t;

	function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
		logic signed [ANG_W-1:0] a;
		case (idx)
			0:       a = ANG_W'(32'h3243_F6A8);
			1:       a = ANG_W'(32'h1DAC_6705);
			2:       a = ANG_W'(32'h0FAD_BAFC);
			3:       a = ANG_W'(32'h07F5_6EA6);
			4:       a = ANG_W'(32'h03FE_AB76);
			5:       a = ANG_W'(32'h01FF_D55B);
			6:       a = ANG_W'(32'h00FF_FAAA);
			7:       a = ANG_W'(32'h007F_FF55);
			8:       a = ANG_W'(32'h003F_FFEA);
			9:       a = ANG_W'(32'h001F_FFFD);
			10:      a = ANG_W'(32'h000F_FFFF);
			11:      a = ANG_W'(32'h0007_FFFF);
			12:      a = ANG_W'(32'h0003_FFFF);
			13:      a = ANG_W'(32'h0001_FFFF);
			14:      a = ANG_W'(32'h0000_FFFF);
			15:      a = ANG_W'(32'h0000_7FFF);
			16:      a = ANG_W'(32'h0000_3FFF);
			17:      a = ANG_W'(32'h0000_1FFF);
			18:      a = ANG_W'(32'h0000_0FFF);
			19:      a = ANG_W'(32'h0000_07FF);
			20:      a = ANG_W'(32'h0000_03FF);
			21:      a = ANG_W'(32'h0000_01FF);
			22:      a = ANG_W'(32'h0000_00FF);
			23:      a = ANG_W'(32'h0000_007F);
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Smallest shift that lifts the period to at least 2^59, the magnitude
	// bound of a scaled heading.
	function automatic int reduce_shift(input logic [63:0] period);
		int q;
		q = 0;
		for (int i = 40; i >= 0; i--) begin
			if ((period << i) >= REDUCE_FLOOR) begin
				q = i;
			end
		end
		return q;
	endfunction

endpackage

// File: design/ddm_angle_reduce.sv
// ----------------------------------------------------------------------------
// ddm_angle_reduce
// Scales the heading, reduces it modulo 2*pi by one compare and subtract
// per stage, and folds it into [-pi/2, pi/2] for the CORDIC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddm_angle_reduce #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pose_valid,
	output logic            pose_ready,
	input  ddm_pkg::pose_t  pose,
	output logic            angle_valid,
	input  logic            angle_ready,
	output ddm_pkg::angle_t angle
);
	import ddm_pkg::*;

	localparam logic [63:0] PERIOD = TWO_PI_Q60 >> (32 - FRAC_BITS);
	localparam int STEPS = reduce_shift(PERIOD) + 1;
	localparam logic [63:0] PERIOD_HI = PERIOD << (STEPS - 1);
	localparam int NST = STEPS + 2;

	logic [NST-1:0] vld_s;
	logic [NST-1:0] vld_in;
	logic [NST:0]   en;

	logic [63:0] rem_s [STEPS+1];
	pose_t       pose_s [STEPS+1];
	angle_t      fold_s;

	logic [63:0]             scaled;
	logic [ANG_W-1:0]        z_raw;
	logic signed [ANG_W-1:0] z_a;
	logic signed [ANG_W-1:0] z_b;
	logic                    flip_a;
	logic                    flip_b;

	assign en[NST] = angle_ready;
	for (genvar k = 0; k < NST; k++) begin : g_en
		assign en[k] = !vld_s[k] || en[k+1];
	end

	assign vld_in = {vld_s[NST-2:0], pose_valid};
	assign pose_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	assign scaled = {{4{pose.heading[31]}}, pose.heading, 28'd0};

	always_comb begin
		z_raw = ANG_W'(rem_s[STEPS] >> (FRAC_BITS - 2));
		if ($signed(z_raw) >= PI_Q30) begin
			z_a = $signed(z_raw) - PI_Q30;
			flip_a = 1'b1;
		end else begin
			z_a = $signed(z_raw);
			flip_a = 1'b0;
		end
		if (z_a > HALF_PI_Q30) begin
			z_b = z_a - PI_Q30;
			flip_b = !flip_a;
		end else begin
			z_b = z_a;
			flip_b = flip_a;
		end
	end

	always_ff @(posedge clk) begin
		// A negative heading is lifted by a multiple of the period first.
		if (en[0]) begin
			rem_s[0] <= scaled[63] ? (scaled + PERIOD_HI) : scaled;
			pose_s[0] <= pose;
		end
		for (int k = 1; k <= STEPS; k++) begin
			if (en[k]) begin
				if (rem_s[k-1] >= (PERIOD << (STEPS - k))) begin
					rem_s[k] <= rem_s[k-1] - (PERIOD << (STEPS - k));
				end else begin
					rem_s[k] <= rem_s[k-1];
				end
				pose_s[k] <= pose_s[k-1];
			end
		end
		if (en[NST-1]) begin
			fold_s.z <= z_b;
			fold_s.flip <= flip_b;
			fold_s.pose <= pose_s[STEPS];
		end
	end

	assign angle_valid = vld_s[NST-1];
	assign angle = fold_s;

endmodule

// File: design/ddm_cordic.sv
// ----------------------------------------------------------------------------
// ddm_cordic
// Rotation-mode CORDIC in Q4.30, one iteration per pipeline stage, giving
// cosine and sine of the folded angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddm_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            angle_valid,
	output logic            angle_ready,
	input  ddm_pkg::angle_t angle,
	output logic            trig_valid,
	input  logic            trig_ready,
	output ddm_pkg::trig_t  trig
);
	import ddm_pkg::*;

	typedef struct packed {
		logic signed [ANG_W-1:0] x;
		logic signed [ANG_W-1:0] y;
		logic signed [ANG_W-1:0] z;
		logic                    flip;
		pose_t                   pose;
	} cstage_t;

	function automatic cstage_t rotate(input cstage_t a, input int i);
		cstage_t                 r;
		logic signed [ANG_W-1:0] dx;
		logic signed [ANG_W-1:0] dy;
		r = a;
		dx = a.y >>> i;
		dy = a.x >>> i;
		if (!a.z[ANG_W-1]) begin
			r.x = a.x - dx;
			r.y = a.y + dy;
			r.z = a.z - atan_q30(i);
		end else begin
			r.x = a.x + dx;
			r.y = a.y - dy;
			r.z = a.z + atan_q30(i);
		end
		return r;
	endfunction

	logic [CORDIC_ITERS-1:0] vld_s;
	logic [CORDIC_ITERS-1:0] vld_in;
	logic [CORDIC_ITERS:0]   en;
	cstage_t                 st_s [CORDIC_ITERS];
	cstage_t                 prev [CORDIC_ITERS];

	assign en[CORDIC_ITERS] = trig_ready;
	for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_en
		assign en[k] = !vld_s[k] || en[k+1];
	end

	assign vld_in = {vld_s[CORDIC_ITERS-2:0], angle_valid};
	assign angle_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < CORDIC_ITERS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	always_comb begin
		prev[0].x = CORDIC_GAIN_Q30;
		prev[0].y = '0;
		prev[0].z = angle.z;
		prev[0].flip = angle.flip;
		prev[0].pose = angle.pose;
		for (int k = 1; k < CORDIC_ITERS; k++) begin
			prev[k] = st_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < CORDIC_ITERS; k++) begin
			if (en[k]) begin
				st_s[k] <= rotate(prev[k], k);
			end
		end
	end

	assign trig_valid = vld_s[CORDIC_ITERS-1];
	assign trig.x = st_s[CORDIC_ITERS-1].x;
	assign trig.y = st_s[CORDIC_ITERS-1].y;
	assign trig.flip = st_s[CORDIC_ITERS-1].flip;
	assign trig.pose = st_s[CORDIC_ITERS-1].pose;

endmodule

// File: design/ddm_products.sv
// ----------------------------------------------------------------------------
// ddm_products
// Six-stage multiply, round and saturate pipeline that turns the pose,
// speeds and trigonometric values into the predicted pose and gains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddm_products #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           trig_valid,
	output logic           trig_ready,
	input  ddm_pkg::trig_t trig,
	output logic           pred_valid,
	input  logic           pred_ready,
	output ddm_pkg::pred_t pred
);
	import ddm_pkg::*;

	localparam int NST = 6;
	localparam int S_DV = 30 + FRAC_BITS;
	localparam int PW = 84;
	localparam int MW = PW - S_DV;
	localparam logic [PW-1:0] RND_DV = PW'(1) << (S_DV - 1);
	localparam logic [51:0] RND_W = 52'(1) << (FRAC_BITS - 1);
	localparam logic [51:0] RND_C = 52'(1) << 29;

	logic [NST-1:0] vld_s;
	logic [NST-1:0] vld_in;
	logic [NST:0]   en;

	logic signed [ANG_W-1:0] ax_full;
	logic signed [ANG_W-1:0] ay_full;

	logic [19:0]        dt_s1;
	logic [31:0]        av_s1, aw_s1, ac_s1, as_s1;
	logic               nv_s1, nw_s1, nc_s1, ns_s1;
	logic signed [31:0] px_s1, py_s1, th_s1;

	logic [19:0]        dt_s2;
	logic [31:0]        ac_s2, as_s2;
	logic [51:0]        dvm_s2, tw_s2, dcm_s2, dsm_s2;
	logic               svc_s2, svs_s2, nw_s2, nc_s2, ns_s2;
	logic signed [31:0] px_s2, py_s2, th_s2;

	logic [19:0]        dt_s3;
	logic [57:0]        pc_lo_s3, pc_hi_s3, ps_lo_s3, ps_hi_s3;
	logic [51:0]        twr_s3;
	logic [22:0]        ncr_s3, nsr_s3;
	logic               svc_s3, svs_s3, nw_s3, nc_s3, ns_s3;
	logic signed [31:0] px_s3, py_s3, th_s3;

	logic [PW-1:0]      full_c, full_s;
	logic signed [63:0] twe;

	logic [19:0]        dt_s4;
	logic [MW-1:0]      dvc_mag_s4, dvs_mag_s4;
	logic               svc_s4, svs_s4;
	logic signed [63:0] hsum_s4;
	logic signed [31:0] nx_s4, ny_s4;
	logic signed [31:0] px_s4, py_s4;

	logic signed [63:0] mc, ms;

	logic [19:0]        dt_s5;
	logic signed [63:0] sx_s5, sy_s5, jx_s5, jy_s5, hsum_s5;
	logic signed [31:0] nx_s5, ny_s5;

	pred_t pred_s6;

	assign en[NST] = pred_ready;
	for (genvar k = 0; k < NST; k++) begin : g_en
		assign en[k] = !vld_s[k] || en[k+1];
	end

	assign vld_in = {vld_s[NST-2:0], trig_valid};
	assign trig_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	assign ax_full = trig.x[ANG_W-1] ? -trig.x : trig.x;
	assign ay_full = trig.y[ANG_W-1] ? -trig.y : trig.y;

	// All products are formed on magnitudes and rounded half away from zero.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			dt_s1 <= trig.pose.step_time;
			av_s1 <= trig.pose.lin_speed[31] ? (~trig.pose.lin_speed + 32'd1)
				: trig.pose.lin_speed;
			aw_s1 <= trig.pose.turn_rate[31] ? (~trig.pose.turn_rate + 32'd1)
				: trig.pose.turn_rate;
			ac_s1 <= ax_full[31:0];
			as_s1 <= ay_full[31:0];
			nv_s1 <= trig.pose.lin_speed[31];
			nw_s1 <= trig.pose.turn_rate[31];
			nc_s1 <= trig.x[ANG_W-1] ^ trig.flip;
			ns_s1 <= trig.y[ANG_W-1] ^ trig.flip;
			px_s1 <= trig.pose.pose_x;
			py_s1 <= trig.pose.pose_y;
			th_s1 <= trig.pose.heading;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dt_s2 <= dt_s1;
			ac_s2 <= ac_s1;
			as_s2 <= as_s1;
			dvm_s2 <= 52'(dt_s1) * 52'(av_s1);
			tw_s2 <= 52'(dt_s1) * 52'(aw_s1);
			dcm_s2 <= 52'(dt_s1) * 52'(ac_s1);
			dsm_s2 <= 52'(dt_s1) * 52'(as_s1);
			svc_s2 <= nv_s1 ^ nc_s1;
			svs_s2 <= nv_s1 ^ ns_s1;
			nw_s2 <= nw_s1;
			nc_s2 <= nc_s1;
			ns_s2 <= ns_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			th_s2 <= th_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dt_s3 <= dt_s2;
			pc_lo_s3 <= 58'(dvm_s2[25:0]) * 58'(ac_s2);
			pc_hi_s3 <= 58'(dvm_s2[51:26]) * 58'(ac_s2);
			ps_lo_s3 <= 58'(dvm_s2[25:0]) * 58'(as_s2);
			ps_hi_s3 <= 58'(dvm_s2[51:26]) * 58'(as_s2);
			twr_s3 <= (tw_s2 + RND_W) >> FRAC_BITS;
			ncr_s3 <= 23'((dcm_s2 + RND_C) >> 30);
			nsr_s3 <= 23'((dsm_s2 + RND_C) >> 30);
			svc_s3 <= svc_s2;
			svs_s3 <= svs_s2;
			nw_s3 <= nw_s2;
			nc_s3 <= nc_s2;
			ns_s3 <= ns_s2;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			th_s3 <= th_s2;
		end
	end

	assign full_c = (PW'(pc_hi_s3) << 26) + PW'(pc_lo_s3) + RND_DV;
	assign full_s = (PW'(ps_hi_s3) << 26) + PW'(ps_lo_s3) + RND_DV;
	assign twe = $signed({12'd0, twr_s3});

	always_ff @(posedge clk) begin
		if (en[3]) begin
			dt_s4 <= dt_s3;
			dvc_mag_s4 <= MW'(full_c >> S_DV);
			dvs_mag_s4 <= MW'(full_s >> S_DV);
			svc_s4 <= svc_s3;
			svs_s4 <= svs_s3;
			hsum_s4 <= 64'(th_s3) + (nw_s3 ? -twe : twe);
			nx_s4 <= nc_s3 ? -$signed(32'(ncr_s3)) : $signed(32'(ncr_s3));
			ny_s4 <= ns_s3 ? -$signed(32'(nsr_s3)) : $signed(32'(nsr_s3));
			px_s4 <= px_s3;
			py_s4 <= py_s3;
		end
	end

	assign mc = $signed(64'(dvc_mag_s4));
	assign ms = $signed(64'(dvs_mag_s4));

	always_ff @(posedge clk) begin
		if (en[4]) begin
			dt_s5 <= dt_s4;
			sx_s5 <= svc_s4 ? (64'(px_s4) - mc) : (64'(px_s4) + mc);
			sy_s5 <= svs_s4 ? (64'(py_s4) - ms) : (64'(py_s4) + ms);
			jx_s5 <= svs_s4 ? ms : -ms;
			jy_s5 <= svc_s4 ? -mc : mc;
			hsum_s5 <= hsum_s4;
			nx_s5 <= nx_s4;
			ny_s5 <= ny_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			pred_s6.new_x <= sat32(sx_s5);
			pred_s6.new_y <= sat32(sy_s5);
			pred_s6.new_heading <= sat32(hsum_s5);
			pred_s6.jac_x_theta <= sat32(jx_s5);
			pred_s6.jac_y_theta <= sat32(jy_s5);
			pred_s6.noise_x_v <= nx_s5;
			pred_s6.noise_y_v <= ny_s5;
			pred_s6.noise_theta_w <= dt_s5;
		end
	end

	assign pred_valid = vld_s[NST-1];
	assign pred = pred_s6;

endmodule

// File: design/diff_drive_motion_model.sv
// ----------------------------------------------------------------------------
// diff_drive_motion_model
// The reduction uses R modulo-2*pi subtract stages (R = 14 at FRAC_BITS = 16).
// Throughput: one word per cycle while the output accepts; the 24-stage
// CORDIC and the reduction stages each take a new word every cycle, and
// stalls hold words in place.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diff_drive_motion_model #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pose_valid,
	output logic           pose_ready,
	input  ddm_pkg::pose_t pose,
	output logic           pred_valid,
	input  logic           pred_ready,
	output ddm_pkg::pred_t pred
);
	import ddm_pkg::*;

	logic   angle_valid;
	logic   angle_ready;
	angle_t angle;
	logic   trig_valid;
	logic   trig_ready;
	trig_t  trig;

	ddm_angle_reduce #(
		.FRAC_BITS(FRAC_BITS)
	) u_reduce (
		.clk        (clk),
		.arst_n     (arst_n),
		.pose_valid (pose_valid),
		.pose_ready (pose_ready),
		.pose       (pose),
		.angle_valid(angle_valid),
		.angle_ready(angle_ready),
		.angle      (angle)
	);

	ddm_cordic u_cordic (
		.clk        (clk),
		.arst_n     (arst_n),
		.angle_valid(angle_valid),
		.angle_ready(angle_ready),
		.angle      (angle),
		.trig_valid (trig_valid),
		.trig_ready (trig_ready),
		.trig       (trig)
	);

	ddm_products #(
		.FRAC_BITS(FRAC_BITS)
	) u_products (
		.clk       (clk),
		.arst_n    (arst_n),
		.trig_valid(trig_valid),
		.trig_ready(trig_ready),
		.trig      (trig),
		.pred_valid(pred_valid),
		.pred_ready(pred_ready),
		.pred      (pred)
	);

endmodule

// File: design/ddm_checker.sv
// ----------------------------------------------------------------------------
// ddm_checker
// Port-level checks on the motion model: output word stability, the
// zero-step result, and readiness when the output side is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           pose_valid,
	input logic           pose_ready,
	input ddm_pkg::pose_t pose,
	input logic           pred_valid,
	input logic           pred_ready,
	input ddm_pkg::pred_t pred
);
	import ddm_pkg::*;

	a_pred_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pred_valid && !pred_ready |=> pred_valid)
		else $error("Output word dropped while stalled.");

	a_pred_stable: assert property (@(posedge clk) disable iff (!arst_n)
		pred_valid && !pred_ready |=> $stable(pred))
		else $error("Output word changed while stalled.");

	a_zero_step: assert property (@(posedge clk) disable iff (!arst_n)
		pred_valid && (pred.noise_theta_w == 20'd0) |->
		(pred.jac_x_theta == 32'sd0) && (pred.jac_y_theta == 32'sd0) &&
		(pred.noise_x_v == 32'sd0) && (pred.noise_y_v == 32'sd0))
		else $error("Zero time step gave nonzero gains.");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!pred_valid |-> pose_ready)
		else $error("Input not ready while the output side is empty.");

endmodule

bind diff_drive_motion_model ddm_checker u_ddm_checker (.*);

// File: tb/sv/diff_drive_motion_model_tb.sv
// ----------------------------------------------------------------------------
// diff_drive_motion_model_tb
// Drives pose words into the differential-drive motion model and checks every
// prediction word against an independent fixed-point predictor. The predictor
// reduces the heading modulo 2*pi and runs its own CORDIC. It then forms the
// updated pose, the Jacobian entries and the noise gains with the same
// rounding and saturation rules. Stimulus is a directed set of corner cases
// followed by random words. Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diff_drive_motion_model_tb;

	import ddm_pkg::*;

	localparam int FRAC = 16;
	localparam int TRIG_STEPS = 24;
	localparam int RANDOM_WORDS = 1000;
	localparam int QUIET_FROM = 850;
	localparam int DRAIN_CYCLES = 60;
	localparam longint TRIG_GAIN = 64'h0000_0000_26DD_3B6A;
	localparam logic [31:0] ARCTAN_Q30 [0:TRIG_STEPS-1] = '{
		32'h3243_F6A8, 32'h1DAC_6705, 32'h0FAD_BAFC, 32'h07F5_6EA6,
		32'h03FE_AB76, 32'h01FF_D55B, 32'h00FF_FAAA, 32'h007F_FF55,
		32'h003F_FFEA, 32'h001F_FFFD, 32'h000F_FFFF, 32'h0007_FFFF,
		32'h0003_FFFF, 32'h0001_FFFF, 32'h0000_FFFF, 32'h0000_7FFF,
		32'h0000_3FFF, 32'h0000_1FFF, 32'h0000_0FFF, 32'h0000_07FF,
		32'h0000_03FF, 32'h0000_01FF, 32'h0000_00FF, 32'h0000_007F
	};

	class motion_checker;
		pred_t expected_preds[$];
		int mismatch_count;

		function new();
			mismatch_count = 0;
		endfunction

		function longint clamp32(longint v);
			longint r;
			r = v;
			if (v > 64'sd2147483647) begin
				r = 64'sd2147483647;
			end else if (v < -64'sd2147483648) begin
				r = -64'sd2147483648;
			end
			return r;
		endfunction

		// Product scaled down by 2^sh, rounded half away from zero.
		function longint round_mul(longint a, longint b, int sh);
			logic [127:0] ua;
			logic [127:0] ub;
			logic [127:0] prod;
			bit neg;
			neg = (a < 0) != (b < 0);
			ua = 128'((a < 0) ? -a : a);
			ub = 128'((b < 0) ? -b : b);
			prod = (ua * ub + (128'd1 << (sh - 1))) >> sh;
			return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
		endfunction

		function void heading_trig(longint th, output longint c, output longint s);
			longint period;
			longint half_turn;
			longint quarter_turn;
			longint r;
			longint z;
			longint x;
			longint y;
			longint dx;
			longint dy;
			bit flip;
			period = longint'(TWO_PI_Q60 >> (32 - FRAC));
			half_turn = longint'(TWO_PI_Q60 >> 31);
			quarter_turn = longint'(TWO_PI_Q60 >> 32);
			r = (th * (longint'(1) << 28)) % period;
			if (r < 0) begin
				r += period;
			end
			z = r >>> (FRAC - 2);
			flip = 1'b0;
			if (z >= half_turn) begin
				z -= half_turn;
				flip = 1'b1;
			end
			if (z > quarter_turn) begin
				z -= half_turn;
				flip = !flip;
			end
			x = TRIG_GAIN;
			y = 0;
			for (int i = 0; i < TRIG_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= longint'(ARCTAN_Q30[i]);
				end else begin
					x += dx;
					y -= dy;
					z += longint'(ARCTAN_Q30[i]);
				end
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			c = x;
			s = y;
		endfunction

		function pred_t predict_motion(pose_t p);
			longint px;
			longint py;
			longint th;
			longint v;
			longint w;
			longint dt;
			longint c;
			longint s;
			longint dv;
			longint dvc;
			longint dvs;
			pred_t r;
			px = longint'($signed(p.pose_x));
			py = longint'($signed(p.pose_y));
			th = longint'($signed(p.heading));
			v = longint'($signed(p.lin_speed));
			w = longint'($signed(p.turn_rate));
			dt = longint'(p.step_time);
			heading_trig(th, c, s);
			dv = dt * v;
			dvc = round_mul(dv, c, 30 + FRAC);
			dvs = round_mul(dv, s, 30 + FRAC);
			r.new_x = 32'(clamp32(px + dvc));
			r.new_y = 32'(clamp32(py + dvs));
			r.new_heading = 32'(clamp32(th + round_mul(dt, w, FRAC)));
			r.jac_x_theta = 32'(clamp32(-dvs));
			r.jac_y_theta = 32'(clamp32(dvc));
			r.noise_x_v = 32'(clamp32(round_mul(dt, c, 30)));
			r.noise_y_v = 32'(clamp32(round_mul(dt, s, 30)));
			r.noise_theta_w = p.step_time;
			return r;
		endfunction

		function void note_pose(pose_t p);
			expected_preds.push_back(predict_motion(p));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("Mismatch on %s: expected %h, got %h", name, want, got);
				end
			end
		endfunction

		function void check_pred(pred_t got);
			pred_t want;
			if (expected_preds.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("Unexpected prediction word %h", got);
				end
				return;
			end
			want = expected_preds.pop_front();
			compare_field("new_x", want.new_x, got.new_x);
			compare_field("new_y", want.new_y, got.new_y);
			compare_field("new_heading", want.new_heading, got.new_heading);
			compare_field("jac_x_theta", want.jac_x_theta, got.jac_x_theta);
			compare_field("jac_y_theta", want.jac_y_theta, got.jac_y_theta);
			compare_field("noise_x_v", want.noise_x_v, got.noise_x_v);
			compare_field("noise_y_v", want.noise_y_v, got.noise_y_v);
			compare_field("noise_theta_w", 32'(want.noise_theta_w), 32'(got.noise_theta_w));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic pose_valid;
	logic pose_ready;
	pose_t pose;
	logic pred_valid;
	logic pred_ready = 1'b0;
	pred_t pred;

	motion_checker sb = new();
	bit quiet_tail = 1'b0;
	bit stall_mode = 1'b1;
	int stall_left = 0;
	int cycle_count = 0;

	diff_drive_motion_model #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pose_valid(pose_valid),
		.pose_ready(pose_ready),
		.pose(pose),
		.pred_valid(pred_valid),
		.pred_ready(pred_ready),
		.pred(pred)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (pred_valid && pred_ready) begin
			sb.check_pred(pred);
		end
		cycle_count++;
		if (cycle_count % 300 == 0) begin
			stall_mode = $urandom_range(0, 2) != 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			pred_ready <= 1'b0;
		end else if (!quiet_tail && stall_mode && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 19) - 1;
			pred_ready <= 1'b0;
		end else begin
			pred_ready <= 1'b1;
		end
	end

	function automatic pose_t build_pose(logic [31:0] x, logic [31:0] y, logic [31:0] th,
			logic [31:0] v, logic [31:0] w, logic [19:0] dt);
		pose_t p;
		p.pose_x = x;
		p.pose_y = y;
		p.heading = th;
		p.lin_speed = v;
		p.turn_rate = w;
		p.step_time = dt;
		return p;
	endfunction

	function automatic pose_t random_pose();
		pose_t p;
		int kind;
		int k;
		kind = $urandom_range(0, 9);
		p = build_pose($urandom, $urandom, $urandom, $urandom, $urandom, 20'($urandom));
		case (kind) inside
			[2:6]: begin
				p.pose_x = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
				p.pose_y = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
				p.heading = $urandom_range(0, 1647099) - 823550;
				p.lin_speed = $urandom_range(0, 1310720) - 655360;
				p.turn_rate = $urandom_range(0, 411774) - 205887;
				p.step_time = 20'($urandom_range(0, 65536));
			end
			7: begin
				p.pose_x = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 1048575)
					: 32'h8000_0000 + $urandom_range(0, 1048575);
				p.pose_y = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 1048575)
					: 32'h8000_0000 + $urandom_range(0, 1048575);
			end
			8: begin
				k = $urandom_range(0, 16) - 8;
				p.heading = $rtoi(k * 102943.70838) + $urandom_range(0, 8) - 4;
				p.lin_speed = $urandom_range(0, 1310720) - 655360;
				p.step_time = 20'($urandom_range(0, 131072));
			end
			9: begin
				if ($urandom_range(0, 1)) begin
					p.step_time = '0;
				end else begin
					p.lin_speed = '0;
				end
			end
			default: begin
			end
		endcase
		return p;
	endfunction

	task automatic send_pose(pose_t p);
		pose <= p;
		pose_valid <= 1'b1;
		do @(posedge clk); while (!pose_ready);
		sb.note_pose(p);
	endtask

	initial begin
		bit idle_mode;
		idle_mode = 1'b1;
		arst_n <= 1'b0;
		pose_valid <= 1'b0;
		pose <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pose(build_pose(0, 0, 0, 0, 0, 0));
		send_pose(build_pose(32'h0001_0000, -131072, 102944, 65536, 65536, 0));
		send_pose(build_pose(0, 0, 0, 65536, 0, 65536));
		send_pose(build_pose(0, 0, 102944, 65536, 0, 65536));
		send_pose(build_pose(0, 0, 205887, 65536, 0, 65536));
		send_pose(build_pose(0, 0, -205887, 65536, 0, 65536));
		send_pose(build_pose(0, 0, 308831, 65536, 0, 65536));
		send_pose(build_pose(0, 0, 411775, 65536, 0, 65536));
		send_pose(build_pose(0, 0, 32'h7FFF_FFFF, 65536, 65536, 65536));
		send_pose(build_pose(0, 0, 32'h8000_0000, 65536, -65536, 65536));
		send_pose(build_pose(32'h7FFF_0000, 0, 0, 32'h7FFF_FFFF, 0, 20'hFFFFF));
		send_pose(build_pose(32'h8000_0000, 0, 0, 32'h8000_0000, 0, 20'hFFFFF));
		send_pose(build_pose(0, 32'h7FFF_FFFF, 102944, 32'h7FFF_FFFF, 0, 20'hFFFFF));
		send_pose(build_pose(0, 32'h8000_0000, -102944, 32'h7FFF_FFFF, 0, 20'hFFFFF));
		send_pose(build_pose(0, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 20'hFFFFF));
		send_pose(build_pose(0, 0, 32'h8000_0000, 0, 32'h8000_0000, 20'hFFFFF));
		send_pose(build_pose('1, '1, '1, '1, '1, '1));
		send_pose(build_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 20'hFFFFF));
		send_pose(build_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 20'd1));
		send_pose(build_pose(0, 0, 1, 1, 1, 1));
		send_pose(build_pose(0, 0, 102943, 65536, 0, 65536));
		send_pose(build_pose(0, 0, 102945, 65536, 0, 65536));
		send_pose(build_pose(0, 0, -1, -65536, -1, 20'h08000));

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == QUIET_FROM) begin
				quiet_tail = 1'b1;
			end
			if (i % 64 == 0) begin
				idle_mode = $urandom_range(0, 2) != 0;
			end
			send_pose(random_pose());
			if (!quiet_tail && idle_mode && $urandom_range(0, 3) == 0) begin
				pose_valid <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
		pose_valid <= 1'b0;

		while (sb.expected_preds.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatch_count == 0 && sb.expected_preds.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
design/ddm_pkg.sv
design/ddm_angle_reduce.sv
design/ddm_cordic.sv
design/ddm_products.sv
design/diff_drive_motion_model.sv
design/ddm_checker.sv
tb/sv/diff_drive_motion_model_tb.sv
